// File: hdl/mte_pkg.sv
// Shared types and constants for the timer expiry engine.
package mte_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = 4;

  localparam logic [2:0] KIND_CREATE = 3'd0;
  localparam logic [2:0] KIND_START  = 3'd1;
  localparam logic [2:0] KIND_RESET  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;
  localparam logic [2:0] KIND_TICK   = 3'd5;

  typedef struct packed {
    logic              load;      // latch input beat
    logic              cmd_exec;  // apply non-tick command
    logic              scan_clr;  // start a scan pass
    logic              scan_step; // compare one slot
    logic              fire;      // retire best slot
    logic [SLOT_W-1:0] idx;
  } mte_cmd_t;

  typedef struct packed {
    logic       found;
    logic [2:0] kind;
    logic       bad;   // status of a non-tick command
  } mte_stat_t;
endpackage

// File: hdl/mte_datapath.sv
// Slot table, scan comparator and re-arm arithmetic.
module mte_datapath import mte_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  mte_cmd_t            cmd,
  input  logic [2:0]          kind,
  input  logic [SLOT_W-1:0]   timer_slot,
  input  logic [31:0]         period,
  input  logic                periodic,
  input  logic [31:0]         now_ms,
  output mte_stat_t           stat,
  output logic [SLOT_W-1:0]   best_slot
);
  logic [NUM_SLOTS-1:0] slot_valid, slot_armed, slot_periodic, cand;
  logic [31:0] slot_period   [NUM_SLOTS];
  logic [31:0] slot_deadline [NUM_SLOTS];
  logic [31:0] slot_arm_order[NUM_SLOTS];
  logic [31:0] arm_counter;
  logic [2:0]  r_kind;
  logic [SLOT_W-1:0] r_slot;
  logic [31:0] r_period, r_now;
  logic        r_periodic;
  logic        found;
  logic [SLOT_W-1:0] best;
  logic [31:0] best_el, best_ord;

  logic [31:0] el, ord, nd_a, nd_b, nd;
  logic        better, is_cand;

  always_comb begin
    el      = r_now - slot_deadline[cmd.idx];
    ord     = slot_arm_order[cmd.idx];
    is_cand = cand[cmd.idx];
    better  = !found || (el > best_el) ||
              ((el == best_el) && ((ord - best_ord) >> 31) != 32'd0);
    nd_a    = slot_deadline[best] + slot_period[best];
    nd_b    = r_now + slot_period[best];
    nd      = (((r_now - nd_a) >> 31) != 32'd0) ? nd_a : nd_b;
  end

  assign stat.found = found;
  assign stat.kind  = r_kind;
  assign stat.bad   = (r_kind > KIND_TICK) ||
                      (r_kind == KIND_CREATE && r_period == 32'd0) ||
                      (r_kind != KIND_CREATE && !slot_valid[r_slot]);
  assign best_slot  = best;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind <= kind; r_slot <= timer_slot; r_period <= period;
      r_periodic <= periodic; r_now <= now_ms;
    end
    if (cmd.scan_step && is_cand && better) begin
      best <= cmd.idx; best_el <= el; best_ord <= ord;
    end
    if (cmd.fire && slot_periodic[best]) begin
      slot_deadline[best]  <= nd;
      slot_arm_order[best] <= arm_counter;
    end
    if (cmd.cmd_exec && !stat.bad) begin
      if (r_kind == KIND_CREATE) slot_period[r_slot] <= r_period;
      if (r_kind == KIND_START || r_kind == KIND_RESET) begin
        slot_deadline[r_slot]  <= r_now + slot_period[r_slot];
        slot_arm_order[r_slot] <= arm_counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0; slot_armed <= '0; slot_periodic <= '0;
      arm_counter <= '0; found <= 1'b0; cand <= '0;
    end else begin
      if (cmd.load) begin
        // candidates are frozen at tick start
        for (int i = 0; i < NUM_SLOTS; i++)
          cand[i] <= slot_valid[i] && slot_armed[i] &&
                     (((now_ms - slot_deadline[i]) >> 31) == 32'd0);
      end
      if (cmd.scan_clr) found <= 1'b0;
      if (cmd.scan_step && is_cand && better) found <= 1'b1;
      if (cmd.fire) begin
        cand[best] <= 1'b0;
        if (slot_periodic[best]) arm_counter <= arm_counter + 32'd1;
        else slot_armed[best] <= 1'b0;
      end
      if (cmd.cmd_exec && !stat.bad) begin
        case (r_kind)
          KIND_CREATE: begin
            slot_valid[r_slot] <= 1'b1; slot_armed[r_slot] <= 1'b0;
            slot_periodic[r_slot] <= r_periodic;
          end
          KIND_START, KIND_RESET: begin
            slot_armed[r_slot] <= 1'b1; arm_counter <= arm_counter + 32'd1;
          end
          KIND_STOP: slot_armed[r_slot] <= 1'b0;
          KIND_DELETE: begin
            slot_armed[r_slot] <= 1'b0; slot_valid[r_slot] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// File: hdl/mte_ctrl.sv
// Sequencer: command execution, tick scan passes, result output.
module mte_ctrl import mte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic              fired,
  output logic [SLOT_W-1:0] fired_slot,
  output logic              last,
  input  mte_stat_t         stat,
  input  logic [SLOT_W-1:0] best_slot,
  output mte_cmd_t          cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_SCAN = 3'd2,
                         S_PICK = 3'd3;
  logic [2:0] state, state_next;
  logic [SLOT_W-1:0] idx;
  logic any;
  // one result held back so last can be set when the next pass finds none
  logic pend, pend_next;
  logic [SLOT_W-1:0] pend_slot;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    state_next = state;
    pend_next = pend;
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        if (stat.kind == KIND_TICK) begin
          cmd.scan_clr = 1'b1; state_next = S_SCAN;
        end else if (out_free) begin
          cmd.cmd_exec = 1'b1; state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (idx == SLOT_W'(NUM_SLOTS - 1)) state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          if (!pend || out_free) begin
            cmd.fire = 1'b1; cmd.scan_clr = 1'b1;
            pend_next = 1'b1; state_next = S_SCAN;
          end
        end else if (out_free) begin
          pend_next = 1'b0; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; pend <= 1'b0; out_valid <= 1'b0; any <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == S_SCAN) idx <= idx + SLOT_W'(1);
      else idx <= '0;
      if (state == S_DEC) any <= 1'b0;
      if (state == S_DEC && stat.kind != KIND_TICK && out_free) begin
        out_valid <= 1'b1; status <= stat.bad; fired <= 1'b0;
        fired_slot <= '0; last <= 1'b1;
      end else if (state == S_PICK && stat.found && (!pend || out_free)) begin
        pend_slot <= best_slot; any <= 1'b1;
        if (pend) begin
          out_valid <= 1'b1; status <= 1'b0; fired <= 1'b1;
          fired_slot <= pend_slot; last <= 1'b0;
        end else if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (state == S_PICK && !stat.found && out_free) begin
        out_valid <= 1'b1; status <= 1'b0; fired <= any;
        fired_slot <= any ? pend_slot : '0; last <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: hdl/multi_timer_expiry_engine.sv
// Top level of the multi-slot software timer engine.
//  channel | signals                                         | dir
//  in      | in_valid/in_ready, kind timer_slot period ...  | in
//  out     | out_valid/out_ready, status fired fired_slot last | out
// A command is latched, then decoded and executed. A tick runs a scan pass over the
// 16 slots (16 compares plus a pick), one pass per fired slot plus one.
// Synchronous reset clears the valid, armed and mode bits at once.
// A stalled output holds the sequencer; no input is taken until the item ends.
module multi_timer_expiry_engine import mte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  input  logic [3:0]        timer_slot,
  input  logic [31:0]       period,
  input  logic              periodic,
  input  logic [31:0]       now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic              fired,
  output logic [3:0]        fired_slot,
  output logic              last
);
  mte_cmd_t  cmd;
  mte_stat_t stat;
  logic [SLOT_W-1:0] best_slot;

  mte_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .fired, .fired_slot, .last, .stat, .best_slot, .cmd
  );

  mte_datapath u_dp (
    .clk, .rst, .cmd, .kind, .timer_slot, .period, .periodic, .now_ms,
    .stat, .best_slot
  );
endmodule

// File: bench/multi_timer_expiry_engine_tb.sv
// Self-checking testbench for the multi-slot timer expiry engine.
module multi_timer_expiry_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mte_pkg::*;

  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;
  localparam int RANDOM_ITEMS = 287;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]  k;
    logic [3:0]  s;
    logic [31:0] p;
    logic        per;
    logic [31:0] t;
  } timer_cmd_t;

  typedef struct packed {
    logic       st;
    logic       fi;
    logic [3:0] sl;
    logic       la;
  } timer_evt_t;

  typedef struct {
    timer_cmd_t c;
    bit         typed;
    timer_evt_t e;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = '0;
  logic [3:0] timer_slot = '0;
  logic [31:0] period = '0;
  logic periodic = 1'b0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status, fired, last;
  logic [3:0] fired_slot;

  multi_timer_expiry_engine dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit          tm_valid [NUM_SLOTS];
  bit          tm_armed [NUM_SLOTS];
  bit          tm_periodic [NUM_SLOTS];
  logic [31:0] tm_period [NUM_SLOTS];
  logic [31:0] tm_deadline [NUM_SLOTS];
  logic [31:0] tm_order [NUM_SLOTS];
  logic [31:0] arm_seq = '0;

  timer_evt_t pending_evts[$];
  plan_row_t  plan[$];
  bit failed = 0;
  int tx_idle = 0, rx_idle = 0;
  bit hold_go = 0, hold_done = 0;
  int hold_cnt = 0;
  int quiet_cnt = 0;

  function automatic bit later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return d[31];
  endfunction

  function automatic void arm_timer(int s, logic [31:0] dl);
    tm_deadline[s] = dl;
    tm_armed[s] = 1;
    tm_order[s] = arm_seq;
    arm_seq = arm_seq + 1;
  endfunction

  function automatic void predict_expiries(timer_cmd_t c);
    bit cand [NUM_SLOTS];
    int best, n;
    bit found;
    logic [31:0] ea, eb, nd;
    timer_evt_t ev;
    n = 0;
    if (c.k == KIND_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        cand[i] = tm_valid[i] && tm_armed[i] && !later(tm_deadline[i], c.t);
      forever begin
        found = 0;
        best = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!cand[i]) continue;
          if (!found) begin
            best = i;
            found = 1;
          end else begin
            ea = c.t - tm_deadline[i];
            eb = c.t - tm_deadline[best];
            if ((ea != eb) ? (ea > eb) : later(tm_order[best], tm_order[i]))
              best = i;
          end
        end
        if (!found) break;
        cand[best] = 0;
        if (tm_periodic[best]) begin
          nd = tm_deadline[best] + tm_period[best];
          if (!later(nd, c.t)) nd = c.t + tm_period[best];
          arm_timer(best, nd);
        end else begin
          tm_armed[best] = 0;
        end
        ev = '{st: 1'b0, fi: 1'b1, sl: best[3:0], la: 1'b0};
        pending_evts.push_back(ev);
        n++;
      end
      if (n == 0) pending_evts.push_back('{1'b0, 1'b0, 4'd0, 1'b1});
      else pending_evts[pending_evts.size()-1].la = 1'b1;
      return;
    end
    ev = '{st: 1'b1, fi: 1'b0, sl: 4'd0, la: 1'b1};
    if (c.k == KIND_CREATE) begin
      if (c.p != 0) begin
        tm_valid[c.s] = 1;
        tm_armed[c.s] = 0;
        tm_periodic[c.s] = c.per;
        tm_period[c.s] = c.p;
        ev.st = 1'b0;
      end
    end else if (c.k < KIND_TICK && tm_valid[c.s]) begin
      ev.st = 1'b0;
      case (c.k)
        KIND_START, KIND_RESET: arm_timer(c.s, c.t + tm_period[c.s]);
        KIND_STOP: tm_armed[c.s] = 0;
        default: begin
          tm_armed[c.s] = 0;
          tm_valid[c.s] = 0;
        end
      endcase
    end
    pending_evts.push_back(ev);
  endfunction

  task automatic issue(timer_cmd_t c, bit typed, timer_evt_t e);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= c.k;
    timer_slot <= c.s;
    period <= c.p;
    periodic <= c.per;
    now_ms <= c.t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_expiries(c);
    if (typed) begin
      void'(pending_evts.pop_back());
      pending_evts.push_back(e);
    end
  endtask

  task automatic add_row(logic [2:0] k, logic [3:0] s, logic [31:0] p, logic per,
                         logic [31:0] t, bit typed = 0, timer_evt_t e = '0);
    plan.push_back('{c: '{k, s, p, per, t}, typed: typed, e: e});
  endtask

  // results
  always @(posedge clk) begin
    timer_evt_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_evts.size() == 0) begin
        $display("%0t: unexpected beat st=%b fi=%b sl=%0d la=%b",
                 $time, status, fired, fired_slot, last);
        failed = 1;
      end else begin
        want = pending_evts.pop_front();
        if (status !== want.st) begin
          $display("%0t: status exp %b got %b", $time, want.st, status);
          failed = 1;
        end
        if (fired !== want.fi) begin
          $display("%0t: fired exp %b got %b", $time, want.fi, fired);
          failed = 1;
        end
        if (fired_slot !== want.sl) begin
          $display("%0t: fired_slot exp %0d got %0d", $time, want.sl, fired_slot);
          failed = 1;
        end
        if (last !== want.la) begin
          $display("%0t: last exp %b got %b", $time, want.la, last);
          failed = 1;
        end
      end
    end
    if (hold_go && !hold_done) begin
      // long back-pressure so the engine fills and stalls its input
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("multi_timer_expiry_engine_tb NOT OK");
      $finish;
    end
  end

  function automatic timer_cmd_t random_cmd(ref logic [31:0] clock_ms);
    timer_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    c.s = $urandom_range(0, 15);
    c.p = $urandom;
    c.per = $urandom_range(0, 1);
    if (r < 40) begin
      c.k = KIND_TICK;
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 20);
    end else if (r < 55) begin
      c.k = KIND_CREATE;
      case ($urandom_range(0, 9))
        0: c.p = 0;
        1: c.p = {1'b1, c.p[30:0]};
        2: ;
        default: c.p = $urandom_range(1, 30);
      endcase
    end else if (r < 75) c.k = KIND_START;
    else if (r < 83) c.k = KIND_RESET;
    else if (r < 90) c.k = KIND_STOP;
    else if (r < 97) c.k = KIND_DELETE;
    else c.k = $urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B;
    c.t = clock_ms;
    return c;
  endfunction

  initial begin
    logic [31:0] clock_ms;
    timer_evt_t ok_evt, bad_evt;
    ok_evt = '{1'b0, 1'b0, 4'd0, 1'b1};
    bad_evt = '{1'b1, 1'b0, 4'd0, 1'b1};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tm_valid[i] = 0;
      tm_armed[i] = 0;
      tm_periodic[i] = 0;
    end

    add_row(KIND_TICK, 4'd0, 32'd0, 1'b0, 32'd0, 1, ok_evt);
    add_row(KIND_START, 4'd3, 32'd0, 1'b0, 32'd5, 1, bad_evt);
    add_row(KIND_STOP, 4'd3, 32'd0, 1'b0, 32'd5, 1, bad_evt);
    add_row(KIND_DELETE, 4'd3, 32'd0, 1'b0, 32'd5, 1, bad_evt);
    add_row(KIND_CREATE, 4'd0, 32'd0, 1'b1, 32'd0, 1, bad_evt);
    add_row(KIND_UNUSED_A, 4'd1, 32'd7, 1'b0, 32'd0, 1, bad_evt);
    add_row(KIND_UNUSED_B, 4'd15, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1, bad_evt);
    add_row(KIND_CREATE, 4'd0, 32'd10, 1'b0, 32'd0, 1, ok_evt);
    add_row(KIND_CREATE, 4'd15, 32'hFFFFFFFF, 1'b1, 32'd0, 1, ok_evt);
    add_row(KIND_CREATE, 4'd5, 32'h80000000, 1'b1, 32'd0, 1, ok_evt);
    add_row(KIND_START, 4'd0, 32'd0, 1'b0, 32'd100);
    add_row(KIND_START, 4'd15, 32'd0, 1'b0, 32'hFFFFFFF0);
    add_row(KIND_START, 4'd5, 32'd0, 1'b0, 32'd0);
    add_row(KIND_CREATE, 4'd7, 32'd5, 1'b1, 32'd0);
    add_row(KIND_STOP, 4'd7, 32'd0, 1'b0, 32'd0, 1, ok_evt); // stop while unarmed
    add_row(KIND_START, 4'd7, 32'd0, 1'b0, 32'd100);
    add_row(KIND_TICK, 4'd0, 32'd0, 1'b0, 32'h80000000);
    add_row(KIND_RESET, 4'd7, 32'd0, 1'b0, 32'd200);
    add_row(KIND_DELETE, 4'd7, 32'd0, 1'b0, 32'd0, 1, ok_evt);
    add_row(KIND_START, 4'd7, 32'd0, 1'b0, 32'd0, 1, bad_evt);
    add_row(KIND_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFFFFFF);
    add_row(KIND_CREATE, 4'd2, 32'd1, 1'b0, 32'd0);
    add_row(KIND_START, 4'd2, 32'd0, 1'b0, 32'hFFFFFFFF); // deadline wraps to zero
    add_row(KIND_TICK, 4'd0, 32'd0, 1'b0, 32'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle = 7;
    rx_idle = 70;
    foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].e);

    clock_ms = 32'd0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
        in_valid <= 1'b0;
        wait (pending_evts.size() == 0);
        @(posedge clk);
        tx_idle = (n == RANDOM_ITEMS / 3) ? 70 : 0;
        rx_idle = (n == RANDOM_ITEMS / 3) ? 7 : 0;
      end
      if (n == 40) hold_go = 1;
      issue(random_cmd(clock_ms), 0, '0);
    end
    in_valid <= 1'b0;

    wait (pending_evts.size() == 0);
    repeat (400) @(posedge clk);
    if (!failed && pending_evts.size() == 0) begin
      $display("multi_timer_expiry_engine_tb OK");
    end else begin
      $display("multi_timer_expiry_engine_tb NOT OK");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/mte_pkg.sv
hdl/mte_datapath.sv
hdl/mte_ctrl.sv
hdl/multi_timer_expiry_engine.sv
bench/multi_timer_expiry_engine_tb.sv
